@@ design/psgl_pkg.sv @@
// shared types, constants and helpers for the sound-chip register write logger
// used by every module of the block; depends on nothing else
package psgl_pkg;

  // chip and register geometry
  localparam int NumChips    = 2;
  localparam int RegsPerChip = 14;
  localparam int ChipW       = (NumChips > 1) ? $clog2(NumChips) : 1;
  localparam int RegW        = (RegsPerChip > 1) ? $clog2(RegsPerChip) : 1;

  // envelope shape register always counts as changed after a write
  localparam int EnvShapeReg = 13;

  // decoupling queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // command codes
  localparam logic [7:0] CmdWrite       = 8'hA0;
  localparam logic [7:0] CmdWaitGeneric = 8'h61;
  localparam logic [7:0] CmdWait60      = 8'h62;
  localparam logic [7:0] CmdWait50      = 8'h63;
  localparam logic [7:0] CmdWaitShort   = 8'h70;
  localparam logic [7:0] CmdEnd         = 8'h66;
  localparam logic [7:0] ChipAddrStep   = 8'h80;

  // wait lengths with dedicated codes
  localparam logic [15:0] Wait60Samples = 16'd735;
  localparam logic [15:0] Wait50Samples = 16'd882;
  localparam logic [15:0] ShortWaitMax  = 16'd16;
  localparam logic [15:0] WaitMax       = 16'hFFFF;

  // command lengths in bytes
  localparam logic [1:0] LenShort = 2'd1;
  localparam logic [1:0] LenLong  = 2'd3;

  // configuration register map
  localparam logic RegChipCount = 1'b0;
  localparam logic [1:0] ChipCountReset = 2'd1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_END   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_END   = 2'd2
  } op_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_OVF,
    ST_SCAN,
    ST_END
  } state_e;

  // classified item travelling from front to back
  typedef struct packed {
    op_kind_e         kind;
    logic [ChipW-1:0] chip;
    logic [RegW-1:0]  reg_idx;
    logic [7:0]       value;
  } op_t;

  // one command of the output stream
  typedef struct packed {
    logic [7:0] command_byte;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic [1:0] byte_count;
  } cmd_t;

  // wait command for a nonzero sample count
  function automatic cmd_t wait_cmd(logic [15:0] n);
    cmd_t c;
    c.command_byte = CmdWaitGeneric;
    c.arg_first    = 8'h00;
    c.arg_second   = 8'h00;
    c.byte_count   = LenShort;
    if (n == Wait60Samples) begin
      c.command_byte = CmdWait60;
    end else if (n == Wait50Samples) begin
      c.command_byte = CmdWait50;
    end else if (n <= ShortWaitMax) begin
      c.command_byte = CmdWaitShort + 8'(n - 16'd1);
    end else begin
      c.arg_first  = n[7:0];
      c.arg_second = n[15:8];
      c.byte_count = LenLong;
    end
    return c;
  endfunction

endpackage

@@ design/psgl_front.sv @@
// front end: accepts input transactions, drops ignored ones, classifies the rest
// depends on psgl_pkg
module psgl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic               chip_select_i,
  input  logic [7:0]         reg_index_i,
  input  logic [7:0]         reg_value_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output psgl_pkg::op_t      op_o
);

  logic finished_q, finished_d;
  logic keep;
  logic accept;

  // once end of data is taken everything is swallowed
  assign in_ready_o = finished_q | ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;

  // classify the item
  always_comb begin
    keep          = 1'b0;
    op_o.kind     = psgl_pkg::OP_WRITE;
    op_o.chip     = psgl_pkg::ChipW'(chip_select_i);
    op_o.reg_idx  = psgl_pkg::RegW'(reg_index_i);
    op_o.value    = reg_value_i;
    unique case (psgl_pkg::action_e'(action_i))
      psgl_pkg::ACT_WRITE: begin
        op_o.kind = psgl_pkg::OP_WRITE;
        keep      = (int'(chip_select_i) < psgl_pkg::NumChips) &&
                    (int'(reg_index_i) < psgl_pkg::RegsPerChip);
      end
      psgl_pkg::ACT_TICK: begin
        op_o.kind = psgl_pkg::OP_TICK;
        keep      = 1'b1;
      end
      psgl_pkg::ACT_END: begin
        op_o.kind = psgl_pkg::OP_END;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = accept & keep & ~finished_q;

  // end-of-playback flag
  always_comb begin
    finished_d = finished_q;
    if (push_o && op_o.kind == psgl_pkg::OP_END) begin
      finished_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finished_q <= 1'b0;
    end else begin
      finished_q <= finished_d;
    end
  end

endmodule

@@ design/psgl_queue.sv @@
// short queue of classified items between front and back
// depends on psgl_pkg
module psgl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  psgl_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output psgl_pkg::op_t op_o
);

  psgl_pkg::op_t                    mem_q [psgl_pkg::QueueDepth];
  logic [psgl_pkg::QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [psgl_pkg::QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [psgl_pkg::QueueCntW-1:0]   count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o  = (count_q == psgl_pkg::QueueCntW'(psgl_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (int'(wr_ptr_q) == psgl_pkg::QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == psgl_pkg::QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

@@ design/psgl_back.sv @@
// back end: shadow registers, change tracking, wait counting and command output
// depends on psgl_pkg
module psgl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          chip_count_i,
  input  logic                op_valid_i,
  input  psgl_pkg::op_t       op_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psgl_pkg::cmd_t      cmd_o,
  output logic                last_o
);

  localparam int NC = psgl_pkg::NumChips;
  localparam int NR = psgl_pkg::RegsPerChip;

  psgl_pkg::state_e state_q, state_d;
  psgl_pkg::op_kind_e kind_q;

  logic [NC-1:0][NR-1:0][7:0] shadow_q;
  logic [NC-1:0][NR-1:0][7:0] emitted_q;
  logic [NC-1:0][NR-1:0]      diff_q;
  logic [15:0]                wait_q;

  logic                       out_valid_q;
  psgl_pkg::cmd_t             cmd_q;
  logic                       last_q;

  logic [NC-1:0][NR-1:0]      pending;
  logic [NC-1:0][NR-1:0]      rest;
  logic                       changed;
  logic [psgl_pkg::ChipW-1:0] sel_c;
  logic [psgl_pkg::RegW-1:0]  sel_r;
  logic                       scan_last;
  logic                       slot_free;
  logic                       emit;
  logic                       load;
  psgl_pkg::cmd_t             cmd_d;
  logic                       last_d;

  // changed registers of the enabled chips
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      pending[c] = (c < int'(chip_count_i)) ? diff_q[c] : '0;
    end
    changed = |pending;
  end

  // lowest changed register, chip-major
  always_comb begin
    sel_c = '0;
    sel_r = '0;
    for (int c = NC - 1; c >= 0; c--) begin
      for (int r = NR - 1; r >= 0; r--) begin
        if (pending[c][r]) begin
          sel_c = psgl_pkg::ChipW'(c);
          sel_r = psgl_pkg::RegW'(r);
        end
      end
    end
    rest = pending;
    rest[sel_c][sel_r] = 1'b0;
    scan_last = (rest == '0);
  end

  assign slot_free = ~out_valid_q | out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psgl_pkg::ST_IDLE: begin
        if (op_valid_i) begin
          unique case (op_i.kind)
            psgl_pkg::OP_TICK: begin
              if (changed) begin
                state_d = (wait_q != '0) ? psgl_pkg::ST_FLUSH : psgl_pkg::ST_SCAN;
              end else if (wait_q == psgl_pkg::WaitMax) begin
                state_d = psgl_pkg::ST_OVF;
              end
            end
            psgl_pkg::OP_END: begin
              state_d = (wait_q != '0) ? psgl_pkg::ST_FLUSH : psgl_pkg::ST_END;
            end
            default: begin
              state_d = psgl_pkg::ST_IDLE;
            end
          endcase
        end
      end
      psgl_pkg::ST_FLUSH: begin
        if (slot_free) begin
          state_d = (kind_q == psgl_pkg::OP_END) ? psgl_pkg::ST_END : psgl_pkg::ST_SCAN;
        end
      end
      psgl_pkg::ST_OVF: begin
        if (slot_free) begin
          state_d = psgl_pkg::ST_IDLE;
        end
      end
      psgl_pkg::ST_SCAN: begin
        if (slot_free && scan_last) begin
          state_d = psgl_pkg::ST_IDLE;
        end
      end
      psgl_pkg::ST_END: begin
        if (slot_free) begin
          state_d = psgl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psgl_pkg::ST_IDLE;
      end
    endcase
  end

  // command selection and queue pop
  always_comb begin
    pop_o  = 1'b0;
    emit   = 1'b0;
    last_d = 1'b0;
    cmd_d  = '{command_byte: psgl_pkg::CmdEnd, arg_first: 8'h00, arg_second: 8'h00,
               byte_count: psgl_pkg::LenShort};
    unique case (state_q)
      psgl_pkg::ST_IDLE: begin
        pop_o = op_valid_i;
      end
      psgl_pkg::ST_FLUSH: begin
        emit  = 1'b1;
        cmd_d = psgl_pkg::wait_cmd(wait_q);
      end
      psgl_pkg::ST_OVF: begin
        emit   = 1'b1;
        last_d = 1'b1;
        cmd_d  = '{command_byte: psgl_pkg::CmdWaitGeneric, arg_first: 8'hFF,
                   arg_second: 8'hFF, byte_count: psgl_pkg::LenLong};
      end
      psgl_pkg::ST_SCAN: begin
        emit   = 1'b1;
        last_d = scan_last;
        cmd_d  = '{command_byte: psgl_pkg::CmdWrite,
                   arg_first: 8'(sel_r) + (sel_c[0] ? psgl_pkg::ChipAddrStep : 8'h00),
                   arg_second: shadow_q[sel_c][sel_r],
                   byte_count: psgl_pkg::LenLong};
      end
      psgl_pkg::ST_END: begin
        emit   = 1'b1;
        last_d = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign load = emit & slot_free;

  // control state, wait counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psgl_pkg::ST_IDLE;
      kind_q      <= psgl_pkg::OP_WRITE;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        kind_q <= op_i.kind;
        if (op_i.kind == psgl_pkg::OP_TICK) begin
          if (changed) begin
            if (wait_q == '0) begin
              wait_q <= 16'd1;
            end
          end else if (wait_q != psgl_pkg::WaitMax) begin
            wait_q <= wait_q + 16'd1;
          end
        end
      end else if (load && state_q == psgl_pkg::ST_FLUSH) begin
        wait_q <= (kind_q == psgl_pkg::OP_END) ? 16'd0 : 16'd1;
      end else if (load && state_q == psgl_pkg::ST_OVF) begin
        wait_q <= 16'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= cmd_d;
      last_q <= last_d;
    end
  end

  // shadow and last-emitted copies with per-register change bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q  <= '0;
      emitted_q <= '0;
      diff_q    <= '0;
    end else begin
      if (pop_o && op_i.kind == psgl_pkg::OP_WRITE) begin
        shadow_q[op_i.chip][op_i.reg_idx] <= op_i.value;
        if (int'(op_i.reg_idx) == psgl_pkg::EnvShapeReg) begin
          emitted_q[op_i.chip][op_i.reg_idx] <= op_i.value + 8'd1;
          diff_q[op_i.chip][op_i.reg_idx]    <= 1'b1;
        end else begin
          diff_q[op_i.chip][op_i.reg_idx] <=
            (op_i.value != emitted_q[op_i.chip][op_i.reg_idx]);
        end
      end else if (load && state_q == psgl_pkg::ST_SCAN) begin
        emitted_q[sel_c][sel_r] <= shadow_q[sel_c][sel_r];
        diff_q[sel_c][sel_r]    <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  // a scan always has a register left to write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == psgl_pkg::ST_SCAN |-> changed)
    else $error("scan state with no changed register");

  // a flush only happens with samples pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == psgl_pkg::ST_FLUSH |-> wait_q != '0)
    else $error("wait flush with zero count");

  // each write command retires exactly one change bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && state_q == psgl_pkg::ST_SCAN) |=>
      $countones(diff_q) == $countones($past(diff_q)) - 1)
    else $error("write command did not retire one change bit");

  // the final command of a run returns the back end to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_d) |=> state_q == psgl_pkg::ST_IDLE)
    else $error("last command not followed by idle");
`endif

endmodule

@@ design/psg_register_log_encoder.sv @@
// Sound-chip register write logger, top level: config register, front, queue, back.
// A register write is absorbed when the back end pops it; a popped sample tick yields
// up to 29 registered commands, an end item one or two. The command loop (one command
// per cycle while the receiver is ready) sets the rate; a two-entry queue lets the front
// keep accepting meanwhile. Reset clears all shadow and emitted copies, the wait count
// and the end flag, and sets chip_count to 1; no clearing pass.
module psg_register_log_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        chip_select_i,
  input  logic [7:0]  reg_index_i,
  input  logic [7:0]  reg_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  command_byte_o,
  output logic [7:0]  arg_first_o,
  output logic [7:0]  arg_second_o,
  output logic [1:0]  byte_count_o,
  output logic        last_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]     chip_count_q;
  logic           cfg_write;
  logic           push;
  logic           queue_full;
  psgl_pkg::op_t  front_op;
  logic           pop;
  logic           op_valid;
  psgl_pkg::op_t  head_op;
  psgl_pkg::cmd_t cmd;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & (paddr[2] == psgl_pkg::RegChipCount);
  assign prdata    = (paddr[2] == psgl_pkg::RegChipCount) ? 32'(chip_count_q) : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_count_q <= psgl_pkg::ChipCountReset;
    end else if (cfg_write) begin
      chip_count_q <= pwdata[1:0];
    end
  end

  // item intake and classification
  psgl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .chip_select_i (chip_select_i),
    .reg_index_i   (reg_index_i),
    .reg_value_i   (reg_value_i),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .op_o          (front_op)
  );

  // decoupling queue
  psgl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (op_valid),
    .op_o    (head_op)
  );

  // command generation
  psgl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chip_count_i (chip_count_q),
    .op_valid_i   (op_valid),
    .op_i         (head_op),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .last_o       (last_of_run_o)
  );

  assign command_byte_o = cmd.command_byte;
  assign arg_first_o    = cmd.arg_first;
  assign arg_second_o   = cmd.arg_second;
  assign byte_count_o   = cmd.byte_count;

endmodule

@@ sim/psg_register_log_encoder_test.sv @@
// Self-checking testbench for the sound-chip register write logger (psg_register_log_encoder).
// Drives register writes, sample ticks and end items, and predicts the command stream in-line.
// Depends on design/psgl_pkg.sv and the RTL of the block.
module psg_register_log_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import psgl_pkg::*;

  localparam int HalfPeriod     = 10;
  localparam int ResetCycles    = 7;
  localparam int SettleCycles   = 64;
  localparam int LongHold       = 300;
  localparam int RandomPerPhase = 30;
  localparam int CycleLimit     = 3_000_000;
  localparam int TotalRegs      = NumChips * RegsPerChip;

  localparam logic [1:0] ActUnused     = 2'd3;
  localparam logic [2:0] AddrChipCount = 3'd0;

  // one expected command of the output stream
  typedef struct packed {
    logic [7:0] code;
    logic [7:0] first;
    logic [7:0] second;
    logic [1:0] len;
    logic       last;
  } log_cmd_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i      = ACT_WRITE;
  logic        chip_select_i = 1'b0;
  logic [7:0]  reg_index_i   = 8'h00;
  logic [7:0]  reg_value_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  command_byte_o;
  logic [7:0]  arg_first_o;
  logic [7:0]  arg_second_o;
  logic [1:0]  byte_count_o;
  logic        last_of_run_o;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [7:0]  shadow_copy  [TotalRegs];
  logic [7:0]  emitted_copy [TotalRegs];
  int unsigned pending_samples;
  bit          log_closed;
  logic [1:0]  chips_enabled;
  log_cmd_t    expected_cmds [$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  no_idle        = 1'b0;
  bit  rx_hold_req    = 1'b0;
  int  rx_stall       = 0;

  psg_register_log_encoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .chip_select_i  (chip_select_i),
    .reg_index_i    (reg_index_i),
    .reg_value_i    (reg_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_byte_o (command_byte_o),
    .arg_first_o    (arg_first_o),
    .arg_second_o   (arg_second_o),
    .byte_count_o   (byte_count_o),
    .last_of_run_o  (last_of_run_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d commands outstanding", $time, expected_cmds.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // random gap length, mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic log_cmd_t make_cmd(logic [7:0] code, logic [7:0] first,
                                        logic [7:0] second, logic [1:0] len);
    log_cmd_t e;
    e.code   = code;
    e.first  = first;
    e.second = second;
    e.len    = len;
    e.last   = 1'b0;
    return e;
  endfunction

  // wait command for a nonzero sample count
  function automatic log_cmd_t wait_entry(int unsigned n);
    if (n == Wait60Samples) return make_cmd(CmdWait60, 8'h00, 8'h00, LenShort);
    if (n == Wait50Samples) return make_cmd(CmdWait50, 8'h00, 8'h00, LenShort);
    if (n <= ShortWaitMax) return make_cmd(CmdWaitShort + 8'(n - 1), 8'h00, 8'h00, LenShort);
    return make_cmd(CmdWaitGeneric, 8'(n), 8'(n >> 8), LenLong);
  endfunction

  // expected commands for one accepted transaction
  task automatic predict_commands(logic [1:0] act, logic chip, logic [7:0] idx,
                                  logic [7:0] val);
    log_cmd_t run [$];
    bit       changed;
    int       nchips;
    int       i;
    if (log_closed) return;
    nchips = (chips_enabled > NumChips) ? NumChips : chips_enabled;
    case (act)
      ACT_WRITE: begin
        if (chip < NumChips && idx < RegsPerChip) begin
          shadow_copy[chip * RegsPerChip + idx] = val;
          // envelope shape write always shows up as a change
          if (idx == EnvShapeReg) emitted_copy[chip * RegsPerChip + idx] = val + 8'd1;
        end
      end
      ACT_TICK: begin
        changed = 1'b0;
        for (i = 0; i < nchips * RegsPerChip; i++)
          if (shadow_copy[i] != emitted_copy[i]) changed = 1'b1;
        if (changed) begin
          if (pending_samples > 0) run.push_back(wait_entry(pending_samples));
          pending_samples = 0;
          for (i = 0; i < nchips * RegsPerChip; i++) begin
            if (shadow_copy[i] != emitted_copy[i])
              run.push_back(make_cmd(CmdWrite,
                                     8'((i % RegsPerChip) + (i / RegsPerChip) * ChipAddrStep),
                                     shadow_copy[i], LenLong));
            emitted_copy[i] = shadow_copy[i];
          end
        end
        pending_samples++;
        // full wait goes out early on overflow
        if (pending_samples >= 65536) begin
          run.push_back(make_cmd(CmdWaitGeneric, WaitMax[7:0], WaitMax[15:8], LenLong));
          pending_samples -= 65535;
        end
      end
      ACT_END: begin
        if (pending_samples > 0) run.push_back(wait_entry(pending_samples));
        pending_samples = 0;
        run.push_back(make_cmd(CmdEnd, 8'h00, 8'h00, LenShort));
        log_closed = 1'b1;
      end
      default: ;
    endcase
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[j]) expected_cmds.push_back(run[j]);
  endtask

  // one input transaction, then a random gap
  task automatic send_item(logic [1:0] act, logic chip, logic [7:0] idx, logic [7:0] val);
    int gap;
    in_valid_i    <= 1'b1;
    action_i      <= act;
    chip_select_i <= chip;
    reg_index_i   <= idx;
    reg_value_i   <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_commands(act, chip, idx, val);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(ACT_TICK, 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // envelope shape write guarantees the next tick emits
  task automatic send_change_tick();
    send_item(ACT_WRITE, 1'b0, 8'(EnvShapeReg), 8'($urandom));
    send_ticks(1);
  endtask

  // sender pause until the stream is drained and the block has settled
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // apb write of chip_count followed by a readback
  task automatic write_chip_count(logic [1:0] value);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrChipCount;
    pwdata  <= {30'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    chips_enabled = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[1:0] !== value) begin
      $display("%0t: chip_count readback mismatch, expected %0h, actual %0h",
               $time, value, rd[1:0]);
      mismatch_count++;
    end
  endtask

  // receiver pacing, with a long hold-off on request
  always @(posedge clk_i) begin : rx_pacing
    int g;
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_stall    = LongHold;
    end
    if (rx_stall > 0) begin
      out_ready_i <= 1'b0;
      rx_stall--;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else begin
      g = pick_gap();
      if (g == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        rx_stall = g - 1;
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    log_cmd_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual %0h %0h %0h len %0d last %0b",
                 $time, command_byte_o, arg_first_o, arg_second_o, byte_count_o,
                 last_of_run_o);
        mismatch_count++;
      end else begin
        want = expected_cmds.pop_front();
        check_field("command_byte", want.code, command_byte_o);
        check_field("arg_first", want.first, arg_first_o);
        check_field("arg_second", want.second, arg_second_o);
        check_field("byte_count", 8'(want.len), 8'(byte_count_o));
        check_field("last_of_run", 8'(want.last), 8'(last_of_run_o));
      end
    end
  end

  // extremes of the fields, ignored writes, disabled chip, envelope shape rewrites
  task automatic test_directed();
    send_ticks(1);
    send_item(ACT_WRITE, 1'b0, 8'd0, 8'h00);
    send_ticks(1);
    send_item(ACT_WRITE, 1'b0, 8'd0, 8'hFF);
    send_item(ACT_WRITE, 1'b0, 8'(EnvShapeReg), 8'h00);
    send_item(ACT_WRITE, 1'b0, 8'(RegsPerChip), 8'h55);
    send_item(ACT_WRITE, 1'b1, 8'hFF, 8'hAA);
    send_item(ActUnused, 1'b1, 8'hFF, 8'hFF);
    send_item(ACT_WRITE, 1'b1, 8'd5, 8'h77);
    send_ticks(1);
    send_item(ACT_WRITE, 1'b0, 8'(EnvShapeReg), 8'hFF);
    send_item(ACT_WRITE, 1'b0, 8'(EnvShapeReg), 8'hFF);
    send_ticks(1);
    send_item(ACT_WRITE, 1'b0, 8'd1, 8'h5A);
    send_item(ACT_WRITE, 1'b0, 8'd1, 8'h00);
    send_ticks(1);
    wait_drain();
    write_chip_count(2'd2);
    send_ticks(1);
    send_item(ACT_WRITE, 1'b1, 8'(EnvShapeReg), 8'h80);
    send_item(ACT_WRITE, 1'b1, 8'd0, 8'h01);
    send_item(ACT_WRITE, 1'b1, 8'd12, 8'hFE);
    send_ticks(1);
    wait_drain();
  endtask

  // short waits at both ends of their range and generic waits from the smallest up
  task automatic test_wait_codes();
    int lengths [7] = '{1, 2, 5, 15, 16, 17, 40};
    no_idle = 1'b1;
    send_change_tick();
    foreach (lengths[i]) begin
      send_ticks(lengths[i] - 1);
      send_change_tick();
    end
    no_idle = 1'b0;
    wait_drain();
  endtask

  // chip_count sweep including zero and the out-of-range value
  task automatic test_chip_count_sweep();
    logic [1:0] settings [4] = '{2'd0, 2'd3, 2'd1, 2'd2};
    foreach (settings[s]) begin
      write_chip_count(settings[s]);
      repeat (4) begin
        send_item(ACT_WRITE, 1'($urandom), 8'($urandom_range(0, RegsPerChip - 1)),
                  8'($urandom));
        send_item(ACT_WRITE, 1'($urandom), 8'($urandom_range(0, RegsPerChip - 1)),
                  8'($urandom));
        send_ticks($urandom_range(1, 3));
      end
      wait_drain();
    end
  endtask

  // receiver holds off while full register sets keep coming
  task automatic test_backpressure();
    int i;
    no_idle = 1'b1;
    rx_hold_req = 1'b1;
    repeat (4) begin
      for (i = 0; i < TotalRegs; i++)
        send_item(ACT_WRITE, 1'(i / RegsPerChip), 8'(i % RegsPerChip),
                  shadow_copy[i] ^ 8'($urandom_range(1, 255)));
      send_ticks(1);
    end
    no_idle = 1'b0;
    wait_drain();
  endtask

  // mostly write bursts closed by a tick, plus tick runs and noise
  task automatic test_random_traffic();
    logic [1:0] phase_cc [4] = '{2'd2, 2'd1, 2'd3, 2'd2};
    int counted;
    int r;
    int k;
    foreach (phase_cc[p]) begin
      write_chip_count(phase_cc[p]);
      no_idle = (p == 2);
      counted = 0;
      while (counted < RandomPerPhase) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          k = $urandom_range(1, 6);
          repeat (k)
            send_item(ACT_WRITE, 1'($urandom), 8'($urandom_range(0, RegsPerChip - 1)),
                      8'($urandom));
          send_ticks(1);
          counted += k + 1;
        end else if (r < 75) begin
          k = $urandom_range(1, 20);
          send_ticks(k);
          counted += k;
        end else if (r < 90) begin
          if ($urandom_range(0, 1))
            send_item(ACT_WRITE, 1'($urandom), 8'($urandom_range(RegsPerChip, 255)),
                      8'($urandom));
          else
            send_item(ActUnused, 1'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          send_item(ACT_WRITE, 1'($urandom), 8'($urandom), 8'($urandom));
          counted++;
        end
      end
      no_idle = 1'b0;
      wait_drain();
    end
  endtask

  // end flushes the wait, then everything is ignored
  task automatic test_end_of_data();
    send_change_tick();
    send_ticks(5);
    send_item(ACT_END, 1'($urandom), 8'($urandom), 8'($urandom));
    send_item(ACT_WRITE, 1'b0, 8'(EnvShapeReg), 8'h3C);
    send_ticks(2);
    send_item(ACT_END, 1'b1, 8'hFF, 8'hFF);
    send_item(ActUnused, 1'b0, 8'h00, 8'h00);
    send_change_tick();
    wait_drain();
  endtask

  initial begin
    foreach (shadow_copy[i]) begin
      shadow_copy[i]  = 8'h00;
      emitted_copy[i] = 8'h00;
    end
    pending_samples = 0;
    log_closed      = 1'b0;
    chips_enabled   = ChipCountReset;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_wait_codes();
    test_chip_count_sweep();
    test_backpressure();
    test_random_traffic();
    test_end_of_data();

    if (mismatch_count == 0 && expected_cmds.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
